/* rtl/rtc_pkg.sv */
// Shared types and constants for the tick catch-up block.
// No dependencies; used by rtc_div and realtime_tick_catchup_top.
`timescale 1ns / 1ps

package rtc_pkg;

  localparam int TIME_W  = 32;
  localparam int STEP_W  = 24;
  localparam int ADDED_W = 9;

  // operation codes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_STEP        = 2'd0;
  localparam logic [1:0] REG_MILLI_BASE  = 2'd1;
  localparam logic [1:0] REG_SECOND_BASE = 2'd2;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'd1089590;

  // catch-up window around the deadline
  localparam logic [TIME_W-1:0]  SPAN_AHEAD    = 32'd256;
  localparam logic [TIME_W-1:0]  SPAN_BEHIND   = 32'hFFFF_FF00;
  localparam logic [ADDED_W-1:0] CATCHUP_LIMIT = 9'd257;

  // x / 1000 == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
  localparam int                 RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP       = 29'd274877907;
  localparam int                 RECIP_SHIFT = 38;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_CATCHUP = 2'd1,
    EV_RESYNC  = 2'd2,
    EV_SETBACK = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ARM,
    ST_STEP,
    ST_TEST,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } rtc_state_t;

endpackage

/* rtl/rtc_div.sv */
// Divide-by-1000 for the seconds report: reciprocal multiply; the dividend is registered, then the product.
// Depends on rtc_pkg.
`timescale 1ns / 1ps

module rtc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rtc_pkg::TIME_W-1:0]  dividend,
  output logic                        done,
  output logic [rtc_pkg::TIME_W-1:0]  quotient
);

  localparam int PROD_W = rtc_pkg::TIME_W + rtc_pkg::RECIP_W;
  localparam int QUO_W  = PROD_W - rtc_pkg::RECIP_SHIFT;

  logic                        loaded;
  logic [rtc_pkg::TIME_W-1:0]  operand;
  logic [PROD_W-1:0]           product;

  assign quotient = {{(rtc_pkg::TIME_W-QUO_W){1'b0}},
                     product[PROD_W-1:rtc_pkg::RECIP_SHIFT]};

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      done   <= 1'b0;
    end else begin
      loaded <= start;
      done   <= loaded;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      operand <= dividend;
    end
    if (loaded) begin
      product <= {{rtc_pkg::RECIP_W{1'b0}}, operand} *
                 {{rtc_pkg::TIME_W{1'b0}}, rtc_pkg::RECIP};
    end
  end

endmodule

/* rtl/realtime_tick_catchup_top.sv */
// Tick catch-up top level: sequencer, deadline accumulator, config registers.
// Depends on rtc_pkg and rtc_div.
`timescale 1ns / 1ps
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | operation, now_ms
//  output   | out_valid / out_ready| advanced, event_kind, ticks_added,
//           |                      | tick_total, date_seconds, date_changed
//  config   | cfg_write            | cfg_index, cfg_data
//
//  One transaction at a time; the seconds report uses a reciprocal multiplier.
//  After acceptance: DECIDE; ARM for start, resync or set-back, STEP and TEST
//  per added tick for catch-up; then DIV_START, DIV_WAIT (divide-by-1000) and
//  OUT. Input is ready again in IDLE, once OUT has registered the result.
//  A finished result waits in the output register; the next input transaction
//  is taken meanwhile, and the sequencer holds before output until it is free.
//  Synchronous reset loads register defaults and clears state, not the payload.

module realtime_tick_catchup_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [31:0]                   now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          advanced,
  output logic [1:0]                    event_kind,
  output logic [8:0]                    ticks_added,
  output logic [31:0]                   tick_total,
  output logic [31:0]                   date_seconds,
  output logic                          date_changed,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int SUM_W = rtc_pkg::STEP_W + 1;

  rtc_pkg::rtc_state_t state, state_next;

  logic [rtc_pkg::STEP_W-1:0]  step_value;
  logic [31:0]                 milli_base;
  logic [31:0]                 second_base;

  logic [31:0]                 last_time;
  logic [31:0]                 deadline_whole;
  logic [FRAC_BITS-1:0]        deadline_fraction;
  logic [31:0]                 tick_count;
  logic [31:0]                 shown_seconds;

  logic                        cur_op;
  logic [31:0]                 cur_now;
  rtc_pkg::event_kind_t        kind;
  logic [rtc_pkg::ADDED_W-1:0] added;

  logic [31:0]                 delta;
  logic [SUM_W-1:0]            step_sum;
  logic [SUM_W-1:0]            arm_sum;
  logic [31:0]                 date_now;
  logic                        out_free;
  logic                        div_start;
  logic                        div_done;
  logic [31:0]                 div_quotient;

  assign delta    = cur_now - deadline_whole;
  assign step_sum = SUM_W'(deadline_fraction) + SUM_W'(step_value);
  assign arm_sum  = SUM_W'(step_value);
  assign date_now = div_quotient + second_base;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == rtc_pkg::ST_IDLE);

  rtc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (last_time - milli_base),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      rtc_pkg::ST_IDLE: begin
        if (in_valid) state_next = rtc_pkg::ST_DECIDE;
      end
      rtc_pkg::ST_DECIDE: begin
        if (cur_op == rtc_pkg::OP_START) begin
          state_next = rtc_pkg::ST_ARM;
        end else if (cur_now == last_time) begin
          state_next = rtc_pkg::ST_DIV_START;
        end else if (!delta[31]) begin
          state_next = (delta > rtc_pkg::SPAN_AHEAD) ? rtc_pkg::ST_ARM : rtc_pkg::ST_STEP;
        end else if (delta < rtc_pkg::SPAN_BEHIND) begin
          state_next = rtc_pkg::ST_ARM;
        end else begin
          state_next = rtc_pkg::ST_DIV_START;
        end
      end
      rtc_pkg::ST_ARM:  state_next = rtc_pkg::ST_DIV_START;
      rtc_pkg::ST_STEP: state_next = rtc_pkg::ST_TEST;
      rtc_pkg::ST_TEST: begin
        if (!delta[31] && added < rtc_pkg::CATCHUP_LIMIT) begin
          state_next = rtc_pkg::ST_STEP;
        end else begin
          state_next = rtc_pkg::ST_DIV_START;
        end
      end
      rtc_pkg::ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = rtc_pkg::ST_DIV_WAIT;
      end
      rtc_pkg::ST_DIV_WAIT: begin
        if (div_done) state_next = rtc_pkg::ST_OUT;
      end
      rtc_pkg::ST_OUT: begin
        if (out_free) state_next = rtc_pkg::ST_IDLE;
      end
      default: state_next = rtc_pkg::ST_IDLE;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_value  <= rtc_pkg::STEP_RESET;
      milli_base  <= '0;
      second_base <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rtc_pkg::REG_STEP:        step_value  <= cfg_data[rtc_pkg::STEP_W-1:0];
        rtc_pkg::REG_MILLI_BASE:  milli_base  <= cfg_data;
        rtc_pkg::REG_SECOND_BASE: second_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time         <= '0;
      deadline_whole    <= '0;
      deadline_fraction <= '0;
      tick_count        <= '0;
      shown_seconds     <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (state == rtc_pkg::ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        rtc_pkg::ST_DECIDE: begin
          if (cur_op == rtc_pkg::OP_START || cur_now != last_time) last_time <= cur_now;
          if (cur_op == rtc_pkg::OP_SAMPLE && cur_now != last_time && !delta[31]
              && delta > rtc_pkg::SPAN_AHEAD) begin
            tick_count <= tick_count + 32'd1;
          end
        end
        rtc_pkg::ST_ARM: begin
          deadline_whole    <= last_time + 32'(arm_sum >> FRAC_BITS);
          deadline_fraction <= arm_sum[FRAC_BITS-1:0];
        end
        rtc_pkg::ST_STEP: begin
          tick_count        <= tick_count + 32'd1;
          deadline_whole    <= deadline_whole + 32'(step_sum >> FRAC_BITS);
          deadline_fraction <= step_sum[FRAC_BITS-1:0];
        end
        rtc_pkg::ST_OUT: begin
          if (out_free) begin
            shown_seconds <= date_now;
          end
        end
        default: ;
      endcase
    end
  end

  // transaction payload and result registers
  always_ff @(posedge clk) begin
    case (state)
      rtc_pkg::ST_IDLE: begin
        cur_op  <= operation;
        cur_now <= now_ms;
      end
      rtc_pkg::ST_DECIDE: begin
        if (cur_op == rtc_pkg::OP_SAMPLE && cur_now != last_time) begin
          if (!delta[31]) begin
            if (delta > rtc_pkg::SPAN_AHEAD) begin
              kind  <= rtc_pkg::EV_RESYNC;
              added <= rtc_pkg::ADDED_W'(1);
            end else begin
              kind  <= rtc_pkg::EV_CATCHUP;
              added <= '0;
            end
          end else if (delta < rtc_pkg::SPAN_BEHIND) begin
            kind  <= rtc_pkg::EV_SETBACK;
            added <= '0;
          end else begin
            kind  <= rtc_pkg::EV_NONE;
            added <= '0;
          end
        end else begin
          kind  <= rtc_pkg::EV_NONE;
          added <= '0;
        end
      end
      rtc_pkg::ST_STEP: added <= added + rtc_pkg::ADDED_W'(1);
      rtc_pkg::ST_OUT: begin
        if (out_free) begin
          advanced     <= (added != '0);
          event_kind   <= kind;
          ticks_added  <= added;
          tick_total   <= tick_count;
          date_seconds <= date_now;
          date_changed <= (date_now != shown_seconds);
        end
      end
      default: ;
    endcase
  end

endmodule
